// ===== rtl/sdds_pkg.sv =====
// Package with the shared types and constants of the directory search block.
`default_nettype none

package sdds_pkg;

	// Length of an 8.3 name pattern in bytes, and the width of its write position.
	localparam int unsigned PAT_LEN  = 11;
	localparam int unsigned BASE_LEN = 8;
	localparam int unsigned POS_W    = 4;

	// Default number of root directory entries.
	localparam int unsigned DIR_ENTRIES_DEFAULT = 224;

	// Character and entry codes.
	localparam logic [7:0] CHR_SPACE    = 8'h20;
	localparam logic [7:0] CHR_DOT      = 8'h2E;
	localparam logic [7:0] CHR_NUL      = 8'h00;
	localparam logic [7:0] CHR_LOWER_A  = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_DELTA   = 8'h20;
	localparam logic [7:0] ENTRY_END    = 8'h00;
	localparam logic [7:0] ENTRY_DELETED = 8'hE5;

	// Reset value of the attribute skip mask: volume label and directory.
	localparam logic [7:0] ATTR_MASK_RESET = 8'h18;

	// Operation carried by an input word.
	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_ENTRY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	// Input word.
	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  char_code;
		logic [63:0] entry_base;
		logic [23:0] entry_ext;
		logic [7:0]  entry_attr;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic       found;
		logic [7:0] entry_index;
	} out_word_t;

	// Decision of the merge stage for one directory entry.
	typedef struct packed {
		logic emit;
		logic found;
		logic advance;
	} decide_t;

endpackage

`default_nettype wire

// ===== rtl/short_name_directory_search_core.sv =====
// Top level of the 8.3 root directory search with the pattern, lanes and result queue.
// A result word is registered into the result queue as the entry word that ends the search is
// accepted. Throughput: one input word per cycle while the queue's spare slot is empty; the eleven
// byte lanes and the merge stage finish an entry within the cycle it is accepted, so the next
// word may depend on its outcome. A two-word result queue lets input continue while a result waits.
// Reset (arst_n low) clears the pattern to spaces, the counters and the queue, and sets the mask to 0x18.
`default_nettype none

module short_name_directory_search_core #(
	parameter int unsigned DIR_ENTRIES = sdds_pkg::DIR_ENTRIES_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sdds_pkg::in_word_t in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sdds_pkg::out_word_t     out_word,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data
);

	localparam int unsigned CNT_W = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIR_ENTRIES - 1);

	logic [7:0]                   attr_mask_q;
	logic [7:0]                   pattern_q [sdds_pkg::PAT_LEN];
	logic [sdds_pkg::POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]             count_q;
	logic                         done_q;

	logic                         accept;
	logic [7:0]                   entry_bytes [sdds_pkg::PAT_LEN];
	logic [sdds_pkg::PAT_LEN-1:0] lane_eq;
	sdds_pkg::decide_t            decide;
	logic                         is_entry;
	logic                         at_last;
	logic [7:0]                   up_char;
	logic [CNT_W+7:0]             count_wide;
	sdds_pkg::out_word_t          result;

	logic                         head_valid_q;
	sdds_pkg::out_word_t          head_q;
	logic                         spare_valid_q;
	sdds_pkg::out_word_t          spare_q;
	logic                         pop;

	assign accept   = in_valid && in_ready;
	assign is_entry = accept && (in_word.opcode == sdds_pkg::OP_ENTRY) && !done_q;
	assign at_last  = (count_q == CNT_LAST);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_mask_q <= sdds_pkg::ATTR_MASK_RESET;
		end else if (cfg_wr_en) begin
			attr_mask_q <= cfg_wr_data;
		end
	end

	// Split the entry name into bytes, one per lane.
	for (genvar k = 0; k < sdds_pkg::PAT_LEN; k++) begin : g_lane
		if (k < sdds_pkg::BASE_LEN) begin : g_base
			assign entry_bytes[k] = in_word.entry_base[8*k +: 8];
		end else begin : g_ext
			assign entry_bytes[k] = in_word.entry_ext[8*(k-sdds_pkg::BASE_LEN) +: 8];
		end
		sdds_lane u_lane (
			.entry_byte   (entry_bytes[k]),
			.pattern_byte (pattern_q[k]),
			.equal        (lane_eq[k])
		);
	end

	sdds_merge u_merge (
		.lane_eq        (lane_eq),
		.first_byte     (entry_bytes[0]),
		.entry_attr     (in_word.entry_attr),
		.attr_skip_mask (attr_mask_q),
		.is_entry       (is_entry),
		.at_last        (at_last),
		.decide         (decide)
	);

	// Upper-case a letter before it enters the pattern.
	always_comb begin
		up_char = in_word.char_code;
		if (in_word.char_code >= sdds_pkg::CHR_LOWER_A &&
			in_word.char_code <= sdds_pkg::CHR_LOWER_Z) begin
			up_char = in_word.char_code - sdds_pkg::CASE_DELTA;
		end
	end

	// Pattern and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdds_pkg::PAT_LEN; i++) begin
				pattern_q[i] <= sdds_pkg::CHR_SPACE;
			end
			pos_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			case (in_word.opcode)
				sdds_pkg::OP_CHAR: begin
					if (in_word.char_code != sdds_pkg::CHR_NUL &&
						pos_q < sdds_pkg::POS_W'(sdds_pkg::PAT_LEN)) begin
						if (in_word.char_code == sdds_pkg::CHR_DOT &&
							pos_q <= sdds_pkg::POS_W'(sdds_pkg::BASE_LEN)) begin
							pos_q <= sdds_pkg::POS_W'(sdds_pkg::BASE_LEN);
						end else begin
							pattern_q[pos_q] <= up_char;
							pos_q            <= pos_q + 1'b1;
						end
					end
				end
				sdds_pkg::OP_ENTRY: begin
					if (decide.emit) begin
						done_q <= 1'b1;
					end
					if (decide.advance) begin
						count_q <= count_q + 1'b1;
					end
				end
				sdds_pkg::OP_CLEAR: begin
					for (int i = 0; i < sdds_pkg::PAT_LEN; i++) begin
						pattern_q[i] <= sdds_pkg::CHR_SPACE;
					end
					pos_q   <= '0;
					count_q <= '0;
					done_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result word for the entry that ends the search.
	assign count_wide = {8'h00, count_q};
	always_comb begin
		result.found       = decide.found;
		result.entry_index = decide.found ? count_wide[7:0] : 8'h00;
	end

	// Two-word result queue: head drives the port, spare catches a word while head waits.
	assign pop = head_valid_q && out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (pop || !head_valid_q) begin
				if (spare_valid_q) begin
					head_valid_q  <= 1'b1;
					spare_valid_q <= decide.emit;
				end else begin
					head_valid_q  <= decide.emit;
				end
			end else if (decide.emit) begin
				spare_valid_q <= 1'b1;
			end
		end
	end

	// Payload of the result queue.
	always_ff @(posedge clk) begin
		if (pop || !head_valid_q) begin
			if (spare_valid_q) begin
				head_q <= spare_q;
				if (decide.emit) begin
					spare_q <= result;
				end
			end else if (decide.emit) begin
				head_q <= result;
			end
		end else if (decide.emit) begin
			spare_q <= result;
		end
	end

	assign in_ready  = !spare_valid_q;
	assign out_valid = head_valid_q;
	assign out_word  = head_q;

	// The spare slot only fills behind a waiting head word.
	a_spare_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> head_valid_q)
		else $error("result queue spare valid without head");

	// A result ends the search.
	a_emit_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		decide.emit |=> done_q)
		else $error("search not marked done after result");

	// A finished search gives no further result.
	a_no_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !decide.emit)
		else $error("result emitted after search end");

	// The entry counter stays within the directory.
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LAST)
		else $error("entry counter beyond directory size");

endmodule

`default_nettype wire

// ===== rtl/sdds_lane.sv =====
// One compare lane: checks a single name byte of an entry against the pattern.
`default_nettype none

module sdds_lane (
	input  wire logic [7:0] entry_byte,
	input  wire logic [7:0] pattern_byte,
	output logic            equal
);

	// Byte equality for this lane.
	assign equal = (entry_byte == pattern_byte);

endmodule

`default_nettype wire

// ===== rtl/sdds_merge.sv =====
// Merge stage: combines the lane results with the entry checks into one decision.
`default_nettype none

module sdds_merge (
	input  wire logic [sdds_pkg::PAT_LEN-1:0] lane_eq,
	input  wire logic [7:0]                   first_byte,
	input  wire logic [7:0]                   entry_attr,
	input  wire logic [7:0]                   attr_skip_mask,
	input  wire logic                         is_entry,
	input  wire logic                         at_last,
	output sdds_pkg::decide_t                 decide
);

	logic end_mark;
	logic eligible;
	logic match;

	// An entry is eligible unless it is deleted or carries a skipped attribute.
	assign end_mark = (first_byte == sdds_pkg::ENTRY_END);
	assign eligible = (first_byte != sdds_pkg::ENTRY_DELETED) &&
		((entry_attr & attr_skip_mask) == 8'h00);
	assign match    = !end_mark && eligible && (&lane_eq);

	// The search ends at the end mark, on a match, or on the last entry.
	always_comb begin
		decide.emit    = is_entry && (end_mark || match || at_last);
		decide.found   = is_entry && match;
		decide.advance = is_entry && !end_mark && !match && !at_last;
	end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the 8.3 root directory search: name and entry words are checked against a model.
`default_nettype none

module testbench;

	localparam int unsigned N_ENTRIES = sdds_pkg::DIR_ENTRIES_DEFAULT;
	localparam int unsigned LIMIT = 400000;

	// Kinds of directory entry that the stimulus builds from the current name pattern.
	typedef enum int {
		E_MISS,
		E_NEAR,
		E_DELETED,
		E_MASKED,
		E_MATCH,
		E_END
	} entry_kind_t;

	// Model of the lookup: it follows every accepted word and queues the search outcomes.
	class dir_search_model;
		logic [7:0]          name_pat [sdds_pkg::PAT_LEN];
		int unsigned         name_pos;
		int unsigned         entry_num;
		bit                  ended;
		logic [7:0]          skip_mask;
		sdds_pkg::out_word_t outcomes [$];
		int                  fails;
		int                  words;
		int                  results;
		int                  hits;

		function new();
			skip_mask = sdds_pkg::ATTR_MASK_RESET;
			fails = 0;
			words = 0;
			results = 0;
			hits = 0;
			restart();
		endfunction

		function void restart();
			for (int k = 0; k < sdds_pkg::PAT_LEN; k++)
				name_pat[k] = sdds_pkg::CHR_SPACE;
			name_pos = 0;
			entry_num = 0;
			ended = 1'b0;
		endfunction

		function void conclude(bit hit, logic [7:0] idx);
			sdds_pkg::out_word_t r;
			r.found = hit;
			r.entry_index = idx;
			outcomes.push_back(r);
			ended = 1'b1;
			if (hit)
				hits++;
		endfunction

		// Notes one accepted input word and works out the outcome it causes, if any.
		function void take_word(sdds_pkg::in_word_t w);
			logic [7:0] c;
			logic [7:0] b [sdds_pkg::PAT_LEN];
			bit hit;
			words++;
			case (w.opcode)
				sdds_pkg::OP_CHAR: begin
					c = w.char_code;
					if (c != sdds_pkg::CHR_NUL && name_pos < sdds_pkg::PAT_LEN) begin
						if (c == sdds_pkg::CHR_DOT && name_pos <= sdds_pkg::BASE_LEN) begin
							name_pos = sdds_pkg::BASE_LEN;
						end else begin
							if (c >= sdds_pkg::CHR_LOWER_A && c <= sdds_pkg::CHR_LOWER_Z)
								c = c - sdds_pkg::CASE_DELTA;
							name_pat[name_pos] = c;
							name_pos++;
						end
					end
				end
				sdds_pkg::OP_CLEAR: begin
					restart();
				end
				sdds_pkg::OP_ENTRY: begin
					if (!ended) begin
						for (int k = 0; k < sdds_pkg::PAT_LEN; k++)
							b[k] = (k < sdds_pkg::BASE_LEN) ? w.entry_base[8*k +: 8]
								: w.entry_ext[8*(k-sdds_pkg::BASE_LEN) +: 8];
						if (b[0] == sdds_pkg::ENTRY_END) begin
							conclude(1'b0, 8'd0);
						end else begin
							hit = (b[0] != sdds_pkg::ENTRY_DELETED) &&
								((w.entry_attr & skip_mask) == 8'h00);
							for (int k = 0; k < sdds_pkg::PAT_LEN; k++)
								if (b[k] != name_pat[k])
									hit = 1'b0;
							if (hit) begin
								conclude(1'b1, entry_num[7:0]);
							end else begin
								entry_num++;
								if (entry_num >= N_ENTRIES)
									conclude(1'b0, 8'd0);
							end
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		// Compares one result word with the oldest outcome waiting.
		function void check_outcome(sdds_pkg::out_word_t got);
			sdds_pkg::out_word_t want;
			results++;
			if (outcomes.size() == 0) begin
				$error("result with no outcome pending: found %0d, entry_index %0d",
					got.found, got.entry_index);
				fails++;
				return;
			end
			want = outcomes.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				fails++;
			end
			if (got.entry_index !== want.entry_index) begin
				$error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
				fails++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	sdds_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_ready;
	sdds_pkg::out_word_t out_word;
	logic                cfg_wr_en;
	logic [7:0]          cfg_wr_data;

	int send_gap_pct;
	int recv_stall_pct;
	int phase_start;
	dir_search_model sb;

	short_name_directory_search_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offers one word with a random gap before it and waits until it is taken.
	task automatic push_word(sdds_pkg::in_word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_word = w;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		sb.take_word(w);
		@(negedge clk);
	endtask

	// A word with every field random; callers overwrite the fields they care about.
	function automatic sdds_pkg::in_word_t noise_word();
		sdds_pkg::in_word_t w;
		w.opcode = sdds_pkg::opcode_t'($urandom_range(3));
		w.char_code = 8'($urandom);
		w.entry_base = {$urandom, $urandom};
		w.entry_ext = 24'($urandom);
		w.entry_attr = 8'($urandom);
		return w;
	endfunction

	task automatic send_char(logic [7:0] c);
		sdds_pkg::in_word_t w;
		w = noise_word();
		w.opcode = sdds_pkg::OP_CHAR;
		w.char_code = c;
		push_word(w);
	endtask

	task automatic send_clear();
		sdds_pkg::in_word_t w;
		w = noise_word();
		w.opcode = sdds_pkg::OP_CLEAR;
		push_word(w);
	endtask

	task automatic send_rsvd();
		sdds_pkg::in_word_t w;
		w = noise_word();
		w.opcode = sdds_pkg::OP_RSVD;
		push_word(w);
	endtask

	// Builds a directory entry of the given kind from the name pattern as it stands now.
	task automatic send_entry(entry_kind_t kind);
		sdds_pkg::in_word_t w;
		logic [63:0] pbase;
		logic [23:0] pext;
		int k;
		w = noise_word();
		w.opcode = sdds_pkg::OP_ENTRY;
		for (int i = 0; i < sdds_pkg::BASE_LEN; i++)
			pbase[8*i +: 8] = sb.name_pat[i];
		for (int i = sdds_pkg::BASE_LEN; i < sdds_pkg::PAT_LEN; i++)
			pext[8*(i-sdds_pkg::BASE_LEN) +: 8] = sb.name_pat[i];
		k = $urandom_range(sdds_pkg::PAT_LEN - 1);
		w.entry_attr = 8'($urandom) & ~sb.skip_mask;
		case (kind)
			E_MISS: begin
				if (w.entry_base[7:0] == sdds_pkg::ENTRY_END)
					w.entry_base[0] = 1'b1;
				if ({w.entry_ext, w.entry_base} == {pext, pbase})
					w.entry_ext[0] = ~w.entry_ext[0];
				w.entry_attr = 8'($urandom);
			end
			E_END: begin
				w.entry_base[7:0] = sdds_pkg::ENTRY_END;
				w.entry_attr = 8'($urandom);
			end
			default: begin
				w.entry_base = pbase;
				w.entry_ext = pext;
				if (kind == E_NEAR) begin
					if (k < sdds_pkg::BASE_LEN)
						w.entry_base[8*k +: 8] ^= 8'($urandom_range(1, 255));
					else
						w.entry_ext[8*(k-sdds_pkg::BASE_LEN) +: 8] ^=
							8'($urandom_range(1, 255));
				end else if (kind == E_DELETED) begin
					w.entry_base[7:0] = sdds_pkg::ENTRY_DELETED;
				end else if (kind == E_MASKED) begin
					w.entry_attr = 8'($urandom);
					if ((w.entry_attr & sb.skip_mask) == 8'h00)
						w.entry_attr |= sb.skip_mask;
				end
			end
		endcase
		push_word(w);
	endtask

	// A likely filename byte: mostly letters, with digits, dots, zeros and raw bytes.
	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(19);
		if (r < 8)
			return sdds_pkg::CHR_LOWER_A + 8'($urandom_range(25));
		if (r < 12)
			return sdds_pkg::CHR_LOWER_A - sdds_pkg::CASE_DELTA + 8'($urandom_range(25));
		if (r < 14)
			return 8'h30 + 8'($urandom_range(9));	// ASCII digit
		if (r < 16)
			return sdds_pkg::CHR_DOT;
		if (r == 16)
			return sdds_pkg::CHR_NUL;
		return 8'($urandom);
	endfunction

	// Holds the input off until every outcome has arrived and the block has gone quiet.
	task automatic settle();
		in_valid = 1'b0;
		while (sb.outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the skip mask; only called once the block is idle.
	task automatic write_mask(logic [7:0] v);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.skip_mask = v;
	endtask

	// One search: clear, a name, some entries and usually a match or an end marker, or else only random noise words.
	task automatic random_search();
		int r;
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 6)) push_word(noise_word());
			return;
		end
		send_clear();
		repeat ($urandom_range(0, 13)) send_char(name_char());
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(99);
			if (r < 30)
				send_entry(E_MISS);
			else if (r < 45)
				send_entry(E_NEAR);
			else if (r < 58)
				send_entry(E_DELETED);
			else if (r < 72)
				send_entry(E_MASKED);
			else if (r < 92)
				send_char(name_char());
			else
				send_rsvd();
		end
		r = $urandom_range(99);
		if (r < 45)
			send_entry(E_MATCH);
		else if (r < 85)
			send_entry(E_END);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) send_entry(entry_kind_t'($urandom_range(5)));
		if ($urandom_range(39) == 0)
			settle();
	endtask

	// A whole directory of misses, ending either on a hit in the last slot or empty-handed.
	task automatic full_scan(bit hit_last);
		send_clear();
		repeat (3) send_char(name_char());
		repeat (N_ENTRIES - 1) send_entry(E_MISS);
		send_entry(hit_last ? E_MATCH : E_MISS);
	endtask

	task automatic random_phase(int words);
		phase_start = sb.words;
		while (sb.words < phase_start + words)
			random_search();
	endtask

	// Receiver: stalls at random and checks each accepted result word.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_outcome(out_word);
		end
	end

	// Watchdog.
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Main sequence.
	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_gap_pct = 31;
		recv_stall_pct = 86;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// An entry of spaces matches the empty name right after reset.
		send_entry(E_MATCH);
		// Lower case, an early dot, a zero byte, a reserved word and skipped entries.
		send_clear();
		send_char(sdds_pkg::CHR_LOWER_A);
		send_char(sdds_pkg::CHR_DOT);
		send_char(sdds_pkg::CHR_LOWER_Z);
		send_char(sdds_pkg::CHR_NUL);
		send_rsvd();
		send_entry(E_DELETED);
		send_entry(E_MASKED);
		send_entry(E_MATCH);
		send_entry(E_END);
		// A full name with a late dot, one byte too many, a near miss and then the end marker.
		send_clear();
		for (int i = 0; i < 9; i++)
			send_char(sdds_pkg::CHR_LOWER_A - sdds_pkg::CASE_DELTA + 8'(i));
		send_char(sdds_pkg::CHR_DOT);
		send_char(sdds_pkg::CHR_LOWER_A + 8'd9);
		send_char(sdds_pkg::CHR_LOWER_A + 8'd10);
		send_entry(E_NEAR);
		send_entry(E_END);

		// Slow sender, very slow receiver, nothing skipped by attribute.
		settle();
		write_mask(8'h00);
		full_scan(1'b0);
		random_phase(190);

		// Roles swapped, every attribute bit skips.
		settle();
		send_gap_pct = 86;
		recv_stall_pct = 31;
		write_mask(8'hFF);
		random_phase(190);

		// Full speed with a random mask and a hit in the last slot.
		settle();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		write_mask(8'($urandom));
		full_scan(1'b1);
		random_phase(190);
		settle();
		repeat (8) @(negedge clk);

		if (sb.outcomes.size() != 0) begin
			$error("%0d search outcomes never arrived", sb.outcomes.size());
			sb.fails++;
		end
		$display("Covered %0d input words and %0d results (%0d hits), including two full scans,",
			sb.words, sb.results, sb.hits);
		$display("under skip masks 0x18, 0x00, 0xFF and a random one, with varied back-pressure.");
		if (sb.fails == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== short_name_directory_search_core.f =====
rtl/sdds_pkg.sv
rtl/sdds_lane.sv
rtl/sdds_merge.sv
rtl/short_name_directory_search_core.sv
test/testbench.sv
